// ===== design/rsbs_pkg.sv =====
// ----------------------------------------------------------------------------
// rsbs_pkg: shared types and constants of the rational sample boundary scheduler
// item payload structs, sequencer states, shared unit opcodes, status codes
// ----------------------------------------------------------------------------
package rsbs_pkg;

  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned FIELD_BITS     = 64;
  localparam int unsigned RATE_BITS      = 32;
  localparam int unsigned ADDR_BITS      = 3;
  localparam logic [RATE_BITS-1:0] RATE_RESET = 32'd48000;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVF      = 2'd2;

  // register index of sample_rate
  localparam logic REG_SAMPLE_RATE = 1'b0;

  typedef struct packed {
    logic [FIELD_BITS-1:0] duration_numerator;
    logic [FIELD_BITS-1:0] duration_denominator;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] boundary_sample;
    logic [FIELD_BITS-1:0] elapsed_numerator;
    logic [FIELD_BITS-1:0] elapsed_denominator;
    logic [1:0]            status;
  } out_item_t;

  typedef enum logic {
    ALU_DIV,
    ALU_MUL
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctrl_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_GCD,
    S_GCD_STEP,
    S_WAIT,
    S_RED1,
    S_RED2,
    S_RED3,
    S_LCM1,
    S_LCM2,
    S_LCM3,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_NORM1,
    S_NORM2,
    S_NORM3,
    S_RATE1,
    S_RATE2,
    S_RATE3,
    S_RATE4,
    S_RATE5,
    S_OUT
  } state_e;

endpackage

// ===== design/rational_sample_boundary_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// rational_sample_boundary_scheduler_core: exact rational elapsed time and
// sample boundary tracker, one shared bit-serial divide / multiply unit
// ----------------------------------------------------------------------------
// sequence: a zero denominator goes straight to the result; otherwise an item
//   needs 13 divides or multiplies of the shared unit plus one divide per
//   euclid step of its four gcd runs, so the gcd operand sizes set its length
// throughput: one item at a time, the next is taken after the result is taken
// reset: elapsed time 0/1, boundary 0, sample_rate 48000, sequencer idle
module rational_sample_boundary_scheduler_core import rsbs_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned W = VALUE_BITS;

  state_e state_q, state_d;
  state_e ret_q, ret_d;     // where to go when the shared unit finishes
  state_e gret_q, gret_d;   // where to go when a gcd run finishes

  // working registers: x/y are the euclid pair, n/dn the current fraction,
  // t0/t1 hold gcds and cofactors between operations
  logic [W-1:0] x_q, x_d, y_q, y_d, n_q, n_d, dn_q, dn_d;
  logic [W-1:0] t0_q, t0_d, t1_q, t1_d;

  // architectural state
  logic [W-1:0]         en_q, en_d, ed_q, ed_d, bnd_q, bnd_d;
  logic [1:0]           status_q, status_d;
  logic [RATE_BITS-1:0] rate_q;

  // shared unit
  alu_ctrl_t    alu_ctrl;
  logic [W-1:0] alu_a, alu_b, alu_lo, alu_hi;
  logic         alu_done;

  logic [W-1:0] in_n, in_d, rate_w;
  logic [W:0]   sum_w;
  logic         hi_ovf;

  // only the low VALUE_BITS bits of each field take part
  assign in_n   = in_item_i.duration_numerator[W-1:0];
  assign in_d   = in_item_i.duration_denominator[W-1:0];
  assign rate_w = W'(rate_q);
  // numerator sum of the cross products, carry means overflow
  assign sum_w  = {1'b0, x_q} + {1'b0, alu_lo};
  assign hi_ovf = (alu_hi != '0);

  rsbs_alu #(.W(W)) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (alu_ctrl),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .lo_o   (alu_lo),
    .hi_o   (alu_hi)
  );

  // config port, single register at offset 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_SAMPLE_RATE) begin
      rate_q <= pwdata;
    end
  end
  assign prdata = (paddr[2] == REG_SAMPLE_RATE) ? rate_q : '0;
  assign pready = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) state_d = (in_d == '0) ? S_OUT : S_GCD;
      S_GCD:      state_d = (y_q == '0) ? gret_q : S_WAIT;
      S_GCD_STEP: state_d = S_GCD;
      S_WAIT:     if (alu_done) state_d = ret_q;
      S_RED1, S_RED2, S_LCM1, S_LCM2, S_LCM3,
      S_NORM1, S_NORM2, S_RATE1, S_RATE2, S_RATE3: state_d = S_WAIT;
      S_RED3, S_NORM3: state_d = S_GCD;
      S_MUL1:     state_d = hi_ovf ? S_OUT : S_WAIT;
      S_MUL2:     state_d = (hi_ovf || sum_w[W]) ? S_OUT : S_WAIT;
      S_MUL3:     state_d = (hi_ovf || alu_lo == '0) ? S_OUT : S_GCD;
      S_RATE4:    state_d = (hi_ovf || dn_q == '0) ? S_OUT : S_WAIT;
      S_RATE5:    state_d = S_OUT;
      S_OUT:      if (out_ready_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and shared unit requests
  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    n_d      = n_q;
    dn_d     = dn_q;
    t0_d     = t0_q;
    t1_d     = t1_q;
    en_d     = en_q;
    ed_d     = ed_q;
    bnd_d    = bnd_q;
    status_d = status_q;
    ret_d    = ret_q;
    gret_d   = gret_q;
    alu_ctrl = '{start: 1'b0, op: ALU_DIV};
    alu_a    = '0;
    alu_b    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          // reduce the duration first
          n_d      = in_n;
          dn_d     = in_d;
          x_d      = in_n;
          y_d      = in_d;
          gret_d   = S_RED1;
          status_d = (in_d == '0) ? ST_ZERO_DEN : ST_OK;
        end
      end
      S_GCD: begin
        if (y_q != '0) begin
          alu_ctrl = '{start: 1'b1, op: ALU_DIV};
          alu_a    = x_q;
          alu_b    = y_q;
          ret_d    = S_GCD_STEP;
        end
      end
      S_GCD_STEP: begin
        x_d = y_q;
        y_d = alu_hi;
      end
      S_RED1: begin
        t0_d     = x_q;
        alu_ctrl = '{start: 1'b1, op: ALU_DIV};
        alu_a    = n_q;
        alu_b    = x_q;
        ret_d    = S_RED2;
      end
      S_RED2: begin
        n_d      = alu_lo;
        alu_ctrl = '{start: 1'b1, op: ALU_DIV};
        alu_a    = dn_q;
        alu_b    = t0_q;
        ret_d    = S_RED3;
      end
      S_RED3: begin
        // common denominator: gcd of elapsed and duration denominators
        dn_d   = alu_lo;
        x_d    = ed_q;
        y_d    = alu_lo;
        gret_d = S_LCM1;
      end
      S_LCM1: begin
        t0_d     = x_q;
        alu_ctrl = '{start: 1'b1, op: ALU_DIV};
        alu_a    = dn_q;
        alu_b    = x_q;
        ret_d    = S_LCM2;
      end
      S_LCM2: begin
        t1_d     = alu_lo;
        alu_ctrl = '{start: 1'b1, op: ALU_DIV};
        alu_a    = ed_q;
        alu_b    = t0_q;
        ret_d    = S_LCM3;
      end
      S_LCM3: begin
        // t1 = left multiplier, t0 = right multiplier
        t0_d     = alu_lo;
        alu_ctrl = '{start: 1'b1, op: ALU_MUL};
        alu_a    = en_q;
        alu_b    = t1_q;
        ret_d    = S_MUL1;
      end
      S_MUL1: begin
        if (hi_ovf) begin
          status_d = ST_OVF;
        end else begin
          x_d      = alu_lo;
          alu_ctrl = '{start: 1'b1, op: ALU_MUL};
          alu_a    = n_q;
          alu_b    = t0_q;
          ret_d    = S_MUL2;
        end
      end
      S_MUL2: begin
        if (hi_ovf || sum_w[W]) begin
          status_d = ST_OVF;
        end else begin
          x_d      = sum_w[W-1:0];
          alu_ctrl = '{start: 1'b1, op: ALU_MUL};
          alu_a    = ed_q;
          alu_b    = t1_q;
          ret_d    = S_MUL3;
        end
      end
      S_MUL3: begin
        if (hi_ovf || alu_lo == '0) begin
          status_d = ST_OVF;
        end else begin
          // reduce the new sum
          n_d    = x_q;
          dn_d   = alu_lo;
          y_d    = alu_lo;
          gret_d = S_NORM1;
        end
      end
      S_NORM1: begin
        t0_d     = x_q;
        alu_ctrl = '{start: 1'b1, op: ALU_DIV};
        alu_a    = n_q;
        alu_b    = x_q;
        ret_d    = S_NORM2;
      end
      S_NORM2: begin
        en_d     = alu_lo;
        alu_ctrl = '{start: 1'b1, op: ALU_DIV};
        alu_a    = dn_q;
        alu_b    = t0_q;
        ret_d    = S_NORM3;
      end
      S_NORM3: begin
        // elapsed time committed, now cancel denominator against the rate
        ed_d   = alu_lo;
        x_d    = alu_lo;
        y_d    = rate_w;
        gret_d = S_RATE1;
      end
      S_RATE1: begin
        t0_d     = x_q;
        alu_ctrl = '{start: 1'b1, op: ALU_DIV};
        alu_a    = rate_w;
        alu_b    = x_q;
        ret_d    = S_RATE2;
      end
      S_RATE2: begin
        t1_d     = alu_lo;
        alu_ctrl = '{start: 1'b1, op: ALU_DIV};
        alu_a    = ed_q;
        alu_b    = t0_q;
        ret_d    = S_RATE3;
      end
      S_RATE3: begin
        dn_d     = alu_lo;
        alu_ctrl = '{start: 1'b1, op: ALU_MUL};
        alu_a    = en_q;
        alu_b    = t1_q;
        ret_d    = S_RATE4;
      end
      S_RATE4: begin
        if (hi_ovf || dn_q == '0) begin
          // keep new elapsed time, keep old boundary
          status_d = ST_OVF;
        end else begin
          alu_ctrl = '{start: 1'b1, op: ALU_DIV};
          alu_a    = alu_lo;
          alu_b    = dn_q;
          ret_d    = S_RATE5;
        end
      end
      S_RATE5: begin
        bnd_d    = alu_lo;
        status_d = ST_OK;
      end
      S_WAIT, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      gret_q   <= S_IDLE;
      en_q     <= '0;
      ed_q     <= W'(1);
      bnd_q    <= '0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      gret_q   <= gret_d;
      en_q     <= en_d;
      ed_q     <= ed_d;
      bnd_q    <= bnd_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    n_q  <= n_d;
    dn_q <= dn_d;
    t0_q <= t0_d;
    t1_q <= t1_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_item_o  = '{
    boundary_sample:     FIELD_BITS'(bnd_q),
    elapsed_numerator:   FIELD_BITS'(en_q),
    elapsed_denominator: FIELD_BITS'(ed_q),
    status:              status_q
  };

endmodule

// ===== design/rsbs_alu.sv =====
// ----------------------------------------------------------------------------
// rsbs_alu: shared bit-serial divide / multiply unit
// restoring divide (quotient, remainder) or shift-add multiply (full product),
// one bit per cycle over one adder
// ----------------------------------------------------------------------------
module rsbs_alu import rsbs_pkg::*; #(
  parameter int unsigned W = VALUE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  alu_ctrl_t    ctrl_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic         done_o,
  output logic [W-1:0] lo_o,
  output logic [W-1:0] hi_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  hi_q, hi_d, lo_q, lo_d, b_q, b_d;
  alu_op_e       op_q, op_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W:0]    t, addend;
  logic [W+1:0]  s;

  // div: trial subtract of the divisor from the shifted remainder
  // mul: conditional add of the multiplicand to the high half
  always_comb begin
    if (op_q == ALU_DIV) begin
      t      = {hi_q, lo_q[W-1]};
      addend = ~{1'b0, b_q};
    end else begin
      t      = {1'b0, hi_q};
      addend = lo_q[0] ? {1'b0, b_q} : '0;
    end
    s = {1'b0, t} + {1'b0, addend} + (W+2)'(op_q == ALU_DIV);
  end

  always_comb begin
    hi_d   = hi_q;
    lo_d   = lo_q;
    b_d    = b_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      hi_d   = '0;
      lo_d   = a_i;
      b_d    = b_i;
      op_d   = ctrl_i.op;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (op_q == ALU_DIV) begin
        if (s[W+1]) begin
          hi_d = s[W-1:0];
          lo_d = {lo_q[W-2:0], 1'b1};
        end else begin
          hi_d = t[W-1:0];
          lo_d = {lo_q[W-2:0], 1'b0};
        end
      end else begin
        hi_d = s[W:1];
        lo_d = {s[0], lo_q[W-1:1]};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ALU_DIV;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    b_q  <= b_d;
  end

  assign done_o = done_q;
  assign lo_o   = lo_q;
  assign hi_o   = hi_q;

endmodule

// ===== design/rsbs_checker.sv =====
// ----------------------------------------------------------------------------
// rsbs_checker: port-level assertions for the scheduler core
// item handshake ordering and result sanity, attached by bind
// ----------------------------------------------------------------------------
module rsbs_checker import rsbs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // one item in flight: never ready for input while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while result pending");

  // an accepted item stops further input next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after accept");

  // a result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("result dropped or changed");

  // status code and denominator sanity
  a_result_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.status != 2'd3 &&
                     out_item_o.elapsed_denominator != '0))
    else $error("bad status or zero denominator");

endmodule

bind rational_sample_boundary_scheduler_core rsbs_checker u_rsbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: rational sample boundary scheduler core
// drives duration items through valid/ready with bursts and stalls, predicts
// the exact elapsed fraction, boundary and status of each item, and checks
// every result item in order; sample_rate is reprogrammed between phases
// ----------------------------------------------------------------------------
module testbench;
  import rsbs_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_item_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_item_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  rational_sample_boundary_scheduler_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state, mirrors the block's registers
  logic [31:0] rate_mdl;
  logic [63:0] el_num, el_den, bnd;

  in_item_t  duration_q[$];
  out_item_t result_q[$];
  int        errors = 0;
  bit        in_fire;
  int        idle_cycles = 0;

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic logic [63:0] mul_ovf(logic [63:0] a, logic [63:0] b, ref bit ovf);
    logic [127:0] p;
    p = a * b;
    if (p[127:64] != 0) ovf = 1'b1;
    return p[63:0];
  endfunction

  // exact rational add, then floor(elapsed * rate)
  function automatic out_item_t advance_elapsed(in_item_t it);
    logic [63:0] n, d, g, lm, rm, ln, rn, den, g4, r, dd, prod;
    logic [64:0] sum;
    bit          ovf, ovf2;
    out_item_t   res;
    n = it.duration_numerator;
    d = it.duration_denominator;
    ovf = 1'b0;
    ovf2 = 1'b0;
    res.status = ST_OK;
    if (d == 0) begin
      res.status = ST_ZERO_DEN;
    end else begin
      g = gcd64(n, d);
      n = n / g;
      d = d / g;
      g = gcd64(el_den, d);
      lm = d / g;
      rm = el_den / g;
      ln = mul_ovf(el_num, lm, ovf);
      rn = mul_ovf(n, rm, ovf);
      sum = {1'b0, ln} + {1'b0, rn};
      if (sum[64]) ovf = 1'b1;
      den = mul_ovf(el_den, lm, ovf);
      if (ovf || den == 0) begin
        res.status = ST_OVF;
      end else begin
        g = gcd64(sum[63:0], den);
        el_num = sum[63:0] / g;
        el_den = den / g;
        g4 = gcd64(el_den, {32'd0, rate_mdl});
        r = {32'd0, rate_mdl} / g4;
        dd = el_den / g4;
        prod = mul_ovf(el_num, r, ovf2);
        if (ovf2 || dd == 0) res.status = ST_OVF;
        else bnd = prod / dd;
      end
    end
    res.boundary_sample = bnd;
    res.elapsed_numerator = el_num;
    res.elapsed_denominator = el_den;
    return res;
  endfunction

  // sampling at the rising edge: predict on input items, check result items
  always @(posedge clk_i) begin
    out_item_t want;
    in_fire <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) result_q.push_back(advance_elapsed(in_item_i));
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item %h", $time, out_item_o);
        end else begin
          want = result_q.pop_front();
          if (want.boundary_sample !== out_item_o.boundary_sample) begin
            errors++;
            $display("%0t: boundary_sample exp %h got %h", $time,
                     want.boundary_sample, out_item_o.boundary_sample);
          end
          if (want.elapsed_numerator !== out_item_o.elapsed_numerator) begin
            errors++;
            $display("%0t: elapsed_numerator exp %h got %h", $time,
                     want.elapsed_numerator, out_item_o.elapsed_numerator);
          end
          if (want.elapsed_denominator !== out_item_o.elapsed_denominator) begin
            errors++;
            $display("%0t: elapsed_denominator exp %h got %h", $time,
                     want.elapsed_denominator, out_item_o.elapsed_denominator);
          end
          if (want.status !== out_item_o.status) begin
            errors++;
            $display("%0t: status exp %0d got %0d", $time, want.status, out_item_o.status);
          end
        end
      end
      // watchdog on handshake progress
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (duration_q.size() != 0) begin
        in_item_i <= duration_q.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: its own stall pattern, with stall-free stretches
  int stall_left = 0;
  int run_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (run_left > 0) begin
      run_left--;
      out_ready_i <= 1'b1;
    end else begin
      run_left = $urandom_range(1, 60);
      stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
      out_ready_i <= (stall_left == 0);
    end
  end

  task automatic write_rate(logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_BITS'(4 * REG_SAMPLE_RATE);
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    rate_mdl = value;
  endtask

  // hold off until every item is taken and every result has come back
  task automatic drain();
    wait (duration_q.size() == 0 && !in_valid_i && result_q.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic in_item_t dur(logic [63:0] n, logic [63:0] d);
    in_item_t it;
    it.duration_numerator = n;
    it.duration_denominator = d;
    return it;
  endfunction

  // mostly well-formed durations over a bounded set of denominators
  function automatic in_item_t rand_duration();
    logic [63:0] dens[18] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 12, 16, 25, 30,
                              44100, 48000, 1000, 1001};
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 3) return dur({$urandom, $urandom}, {$urandom, $urandom});
    if (k < 6) return dur({$urandom, $urandom}, 0);
    if (k < 8) return dur(ALL_ONES, dens[$urandom_range(0, 17)]);
    if (k < 10) return dur(0, {$urandom, $urandom});
    return dur($urandom_range(0, 4095) * dens[$urandom_range(0, 17)] / 4,
               dens[$urandom_range(0, 17)] * $urandom_range(1, 3));
  endfunction

  task automatic random_phase(int count);
    repeat (count) duration_q.push_back(rand_duration());
    drain();
  endtask

  initial begin
    rate_mdl = RATE_RESET;
    el_num = 0;
    el_den = 1;
    bnd = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero denominators, extremes, reduction, addition overflow
    duration_q.push_back(dur(0, 0));
    duration_q.push_back(dur(ALL_ONES, 0));
    duration_q.push_back(dur(0, ALL_ONES));
    duration_q.push_back(dur(ALL_ONES, ALL_ONES));
    duration_q.push_back(dur(5, 10));
    duration_q.push_back(dur(3, 48000));
    duration_q.push_back(dur(1, 3));
    duration_q.push_back(dur(ALL_ONES, 2));
    duration_q.push_back(dur(1, ALL_ONES));
    duration_q.push_back(dur(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));
    duration_q.push_back(dur(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
    duration_q.push_back(dur(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001));
    duration_q.push_back(dur(7, 44100));
    drain();

    random_phase(300);
    write_rate(32'd1);
    random_phase(250);
    write_rate(32'hFFFF_FFFF);
    random_phase(250);
    write_rate(32'd44100);
    random_phase(250);
    write_rate(32'd0);
    random_phase(100);
    write_rate($urandom);
    random_phase(250);

    // boundary overflow keeps the new elapsed time, then an add overflow keeps the old one
    write_rate(32'hFFFF_FFFF);
    duration_q.push_back(dur(64'h0000_0100_0000_0000, 1));
    duration_q.push_back(dur(1, 2));
    duration_q.push_back(dur(ALL_ONES, 1));
    drain();

    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
